@@ sv/pdsc_pkg.sv @@
// shared types and constants of the path dot-segment collapser
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdsc_pkg;

  localparam int unsigned MaxUnits   = 256;
  localparam int unsigned MaxSegs    = 128;
  localparam int unsigned UnitW      = 16;
  localparam int unsigned IdxW       = $clog2(MaxUnits);
  localparam int unsigned LenW       = IdxW + 1;
  localparam int unsigned BankAddrW  = IdxW - 1;
  localparam int unsigned SegAddrW   = $clog2(MaxSegs);
  localparam int unsigned SegCntW    = SegAddrW + 1;
  localparam int unsigned EscW       = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [UnitW-1:0] UnitDot       = 16'h002E;
  localparam logic [UnitW-1:0] UnitSlash     = 16'h002F;
  localparam logic [UnitW-1:0] UnitBackslash = 16'h005C;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef struct packed {
    req_e             kind;
    logic [UnitW-1:0] unit;
    logic             is_sep;
    logic             is_dot;
    logic [IdxW-1:0]  index;
  } cmd_t;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic [LenW-1:0]  length;
    logic [EscW-1:0]  escapes;
    logic             overflow;
  } res_t;

endpackage

`default_nettype wire

@@ sv/pdsc_front.sv @@
// front end: takes input items and classifies each code unit
// depends on pdsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdsc_front (
  input  wire logic                    s_valid_i,
  output logic                         s_ready_o,
  input  wire logic [1:0]              req_type_i,
  input  wire logic [pdsc_pkg::UnitW-1:0] code_unit_i,
  input  wire logic [pdsc_pkg::IdxW-1:0]  read_index_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output pdsc_pkg::cmd_t               q_data_o
);

  pdsc_pkg::req_e kind;

  assign kind      = pdsc_pkg::req_e'(req_type_i);
  assign s_ready_o = ~q_full_i;
  // unused request code is taken and dropped here
  assign q_push_o  = s_valid_i & ~q_full_i & (kind != pdsc_pkg::REQ_NONE);

  always_comb begin
    q_data_o.kind   = kind;
    q_data_o.unit   = code_unit_i;
    q_data_o.is_sep = (code_unit_i == pdsc_pkg::UnitSlash) ||
                      (code_unit_i == pdsc_pkg::UnitBackslash);
    q_data_o.is_dot = (code_unit_i == pdsc_pkg::UnitDot);
    q_data_o.index  = read_index_i;
  end

endmodule

`default_nettype wire

@@ sv/pdsc_queue.sv @@
// short command queue between front and back end
// depends on pdsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdsc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pdsc_pkg::cmd_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output pdsc_pkg::cmd_t      pop_data_o
);

  localparam int unsigned PtrW = pdsc_pkg::QueuePtrW;

  pdsc_pkg::cmd_t  mem_q [pdsc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == (PtrW+1)'(pdsc_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/pdsc_back.sv @@
// back end: path state, segment stack, canonical buffer and result register
// depends on pdsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdsc_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire pdsc_pkg::cmd_t q_data_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  wire logic           m_ready_i,
  output pdsc_pkg::res_t      m_data_o
);

  localparam int unsigned UnitW = pdsc_pkg::UnitW;
  localparam int unsigned IdxW  = pdsc_pkg::IdxW;
  localparam int unsigned LenW  = pdsc_pkg::LenW;
  localparam int unsigned BankW = pdsc_pkg::BankAddrW;
  localparam int unsigned SegAW = pdsc_pkg::SegAddrW;
  localparam int unsigned SegCW = pdsc_pkg::SegCntW;
  localparam int unsigned EscW  = pdsc_pkg::EscW;

  // canonical buffer split by address parity: two writes per item at most
  logic [UnitW-1:0] bank0_mem [2**BankW];
  logic [UnitW-1:0] bank1_mem [2**BankW];
  logic [LenW-2:0]  seg_mem   [pdsc_pkg::MaxSegs];

  logic [LenW-1:0]  wp_q, wp_d;
  logic [LenW-1:0]  in_cnt_q, in_cnt_d;
  logic [SegCW-1:0] seg_cnt_q, seg_cnt_d;
  logic [EscW-1:0]  esc_q, esc_d;
  logic [1:0]       seg_len_q, seg_len_d;
  logic             all_dots_q, all_dots_d;
  logic             fresh_q, fresh_d;
  logic             in_seg_q, in_seg_d;
  logic             over_q, over_d;
  logic [LenW-1:0]  final_len_q, final_len_d;
  logic [LenW-1:0]  seg_begin_q, seg_begin_d;
  logic [LenW-1:0]  top_q, top_d;
  logic [LenW-2:0]  below_q;

  logic             fire, close_en, finish_en, read_en;
  logic             wa_en, wb_en, push_en;
  logic [LenW-1:0]  wa_addr, wb_addr;
  logic [UnitW-1:0] wb_data;
  logic             b0_en, b1_en;
  logic [BankW-1:0] b0_addr, b1_addr;
  logic [UnitW-1:0] b0_data, b1_data;
  logic [SegCW-1:0] below_idx;

  logic             m_valid_q, m_valid_d;
  logic [LenW-1:0]  res_len_q, res_len_d;
  logic [EscW-1:0]  res_esc_q, res_esc_d;
  logic             res_over_q, res_over_d;
  logic             hit_q, hit_d;
  logic             bank_q;
  logic [UnitW-1:0] rd0_q, rd1_q;

  assign fire    = q_valid_i &&
                   (q_data_i.kind == pdsc_pkg::REQ_APPEND || !m_valid_q || m_ready_i);
  assign q_pop_o = fire;

  always_comb begin
    wp_d        = wp_q;
    in_cnt_d    = in_cnt_q;
    seg_cnt_d   = seg_cnt_q;
    esc_d       = esc_q;
    seg_len_d   = seg_len_q;
    all_dots_d  = all_dots_q;
    fresh_d     = fresh_q;
    in_seg_d    = in_seg_q;
    over_d      = over_q;
    final_len_d = final_len_q;
    seg_begin_d = seg_begin_q;
    top_d       = top_q;
    close_en    = 1'b0;
    finish_en   = 1'b0;
    read_en     = 1'b0;
    wa_en       = 1'b0;
    wa_addr     = wp_q;
    wb_en       = 1'b0;
    wb_addr     = wp_q;
    wb_data     = q_data_i.unit;
    push_en     = 1'b0;
    res_len_d   = res_len_q;
    res_esc_d   = res_esc_q;
    res_over_d  = res_over_q;
    hit_d       = hit_q;

    if (fire) begin
      unique case (q_data_i.kind)
        pdsc_pkg::REQ_APPEND: begin
          if (in_cnt_q >= LenW'(pdsc_pkg::MaxUnits)) begin
            over_d = 1'b1;
          end else begin
            in_cnt_d = in_cnt_q + LenW'(1);
            fresh_d  = 1'b0;
            // leading separator, or separator ahead of a new segment
            wa_en    = ((fresh_q && q_data_i.is_sep) ||
                        (!q_data_i.is_sep && !in_seg_q && seg_cnt_q != '0)) && !wp_q[IdxW];
            wa_addr  = wp_q;
            wp_d     = wp_q + LenW'(wa_en);
            if (q_data_i.is_sep) begin
              close_en = 1'b1;
            end else begin
              if (!in_seg_q) begin
                in_seg_d    = 1'b1;
                seg_begin_d = wp_q;
              end
              wb_addr = wp_d;
              wb_en   = !wp_d[IdxW];
              wp_d    = wp_d + LenW'(wb_en);
              if (seg_len_q != 2'd3) begin
                seg_len_d = seg_len_q + 2'd1;
              end
              if (!q_data_i.is_dot) begin
                all_dots_d = 1'b0;
              end
            end
          end
        end
        pdsc_pkg::REQ_FINISH: begin
          close_en  = 1'b1;
          finish_en = 1'b1;
        end
        pdsc_pkg::REQ_READ: begin
          read_en = 1'b1;
          hit_d   = (LenW'(q_data_i.index) < final_len_q);
        end
        default: ;
      endcase
    end

    if (close_en) begin
      if (in_seg_q && seg_len_q != 2'd0) begin
        if (all_dots_q && seg_len_q == 2'd1) begin
          wp_d = seg_begin_q;
        end else if (all_dots_q && seg_len_q == 2'd2) begin
          wp_d = seg_begin_q;
          if (seg_cnt_q == '0) begin
            if (esc_q != '1) begin
              esc_d = esc_q + EscW'(1);
            end
          end else begin
            seg_cnt_d = seg_cnt_q - SegCW'(1);
            wp_d      = top_q;
            top_d     = {1'b0, below_q};
          end
        end else if (seg_cnt_q < SegCW'(pdsc_pkg::MaxSegs)) begin
          push_en   = 1'b1;
          top_d     = seg_begin_q;
          seg_cnt_d = seg_cnt_q + SegCW'(1);
        end else begin
          wp_d   = seg_begin_q;
          over_d = 1'b1;
        end
      end
      seg_len_d  = 2'd0;
      all_dots_d = 1'b1;
      in_seg_d   = 1'b0;
    end

    if (finish_en) begin
      res_len_d   = wp_d;
      res_esc_d   = esc_d;
      res_over_d  = over_d;
      hit_d       = 1'b0;
      final_len_d = wp_d;
      wp_d        = '0;
      in_cnt_d    = '0;
      seg_cnt_d   = '0;
      esc_d       = '0;
      seg_len_d   = 2'd0;
      all_dots_d  = 1'b1;
      fresh_d     = 1'b1;
      in_seg_d    = 1'b0;
      over_d      = 1'b0;
      seg_begin_d = '0;
    end

    if (read_en) begin
      res_len_d  = '0;
      res_esc_d  = '0;
      res_over_d = 1'b0;
    end
  end

  always_comb begin
    b0_en   = 1'b0;
    b0_addr = wa_addr[IdxW-1:1];
    b0_data = pdsc_pkg::UnitBackslash;
    b1_en   = 1'b0;
    b1_addr = wa_addr[IdxW-1:1];
    b1_data = pdsc_pkg::UnitBackslash;
    if (wa_en) begin
      if (wa_addr[0]) begin
        b1_en = 1'b1;
      end else begin
        b0_en = 1'b1;
      end
    end
    if (wb_en) begin
      if (wb_addr[0]) begin
        b1_en   = 1'b1;
        b1_addr = wb_addr[IdxW-1:1];
        b1_data = wb_data;
      end else begin
        b0_en   = 1'b1;
        b0_addr = wb_addr[IdxW-1:1];
        b0_data = wb_data;
      end
    end
  end

  // entry under the top of the stack, read ahead from the next stack count
  assign below_idx = seg_cnt_d - SegCW'(2);

  always_ff @(posedge clk_i) begin
    if (b0_en) begin
      bank0_mem[b0_addr] <= b0_data;
    end
    if (b1_en) begin
      bank1_mem[b1_addr] <= b1_data;
    end
    if (read_en) begin
      rd0_q  <= bank0_mem[q_data_i.index[IdxW-1:1]];
      rd1_q  <= bank1_mem[q_data_i.index[IdxW-1:1]];
      bank_q <= q_data_i.index[0];
    end
    if (push_en) begin
      seg_mem[seg_cnt_q[SegAW-1:0]] <= seg_begin_q[LenW-2:0];
    end
    below_q <= seg_mem[below_idx[SegAW-1:0]];
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (finish_en || read_en) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      in_cnt_q    <= '0;
      seg_cnt_q   <= '0;
      esc_q       <= '0;
      seg_len_q   <= 2'd0;
      all_dots_q  <= 1'b1;
      fresh_q     <= 1'b1;
      in_seg_q    <= 1'b0;
      over_q      <= 1'b0;
      final_len_q <= '0;
      seg_begin_q <= '0;
      m_valid_q   <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      in_cnt_q    <= in_cnt_d;
      seg_cnt_q   <= seg_cnt_d;
      esc_q       <= esc_d;
      seg_len_q   <= seg_len_d;
      all_dots_q  <= all_dots_d;
      fresh_q     <= fresh_d;
      in_seg_q    <= in_seg_d;
      over_q      <= over_d;
      final_len_q <= final_len_d;
      seg_begin_q <= seg_begin_d;
      m_valid_q   <= m_valid_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q      <= top_d;
    res_len_q  <= res_len_d;
    res_esc_q  <= res_esc_d;
    res_over_q <= res_over_d;
  end

  assign m_valid_o         = m_valid_q;
  assign m_data_o.unit     = hit_q ? (bank_q ? rd1_q : rd0_q) : '0;
  assign m_data_o.length   = res_len_q;
  assign m_data_o.escapes  = res_esc_q;
  assign m_data_o.overflow = res_over_q;

endmodule

`default_nettype wire

@@ sv/path_dot_segment_collapser_unit.sv @@
// top level of the path dot-segment collapser: front end, queue, back end
// depends on pdsc_pkg, pdsc_front, pdsc_queue, pdsc_back
`timescale 1ns / 1ps
`default_nettype none

// input stream: tuser carries the request (append, finish, read), tdata the
// code unit and the read index. output stream: one item per finish or read,
// carrying the canonical unit, path length, escape count and overflow flag.
// an append gives no output item; request code 3 is taken and dropped.
// one item is taken per cycle while the queue has room; a result passes
// through the four-entry queue and then the back end, whose path
// state and segment stack update once per item, and whose buffer read port
// is registered into the output stage.
// when the receiver stalls the result holds; appends keep running in the
// back end, a finish or read waits behind the held result, and tready falls
// once the queue is full.
// after reset a new path is open, the finished length is zero, and the
// buffer and stack memories are not reset; no clearing pass is needed.

module path_dot_segment_collapser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // code_unit[15:0], read_index[23:16]
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata   // unit_out[15:0], path_length[24:16],
                                          // escape_count[32:25], overflow[33]
);

  logic           q_full, q_push, q_valid, q_pop;
  pdsc_pkg::cmd_t q_in, q_out;
  pdsc_pkg::res_t res;

  pdsc_front u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .req_type_i   (s_axis_tuser),
    .code_unit_i  (s_axis_tdata[15:0]),
    .read_index_i (s_axis_tdata[23:16]),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in)
  );

  pdsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  pdsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (res)
  );

  assign m_axis_tdata = {6'd0, res.overflow, res.escapes, res.length, res.unit};

endmodule

`default_nettype wire

@@ sim/path_dot_segment_collapser_unit_tb.sv @@
// self-checking testbench for path_dot_segment_collapser_unit: directed and random
// paths go in over the input stream, and a built-in predictor checks every output item
// depends on pdsc_pkg and path_dot_segment_collapser_unit
`timescale 1ns / 1ps

module path_dot_segment_collapser_unit_tb;
  import pdsc_pkg::*;

  typedef struct {
    req_e             kind;
    logic [UnitW-1:0] unit;
    logic [IdxW-1:0]  index;
    bit               drain;
  } path_req_t;

  typedef enum logic [1:0] {
    RX_OPEN, RX_RANDOM, RX_EVERY_FOURTH, RX_CHOKED
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  path_dot_segment_collapser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // requests waiting to be sent and results still owed by the block
  path_req_t req_q[$];
  res_t      canon_result_q[$];
  bit        hold_next = 1'b0;
  int        n_items = 0;
  int        results_due = 0;
  int        results_seen = 0;
  int        n_errors = 0;
  int        n_append = 0, n_finish = 0, n_read = 0, n_over_paths = 0, n_escapes = 0;

  // predicted state of the collapser
  logic [UnitW-1:0] canon_mem [MaxUnits];
  logic [LenW-1:0]  seg_start [MaxSegs];
  logic [LenW-1:0]  wr_pos, in_count, seg_begin;
  logic [LenW-1:0]  done_len = '0;
  logic [SegCntW-1:0] seg_cnt;
  logic [EscW-1:0]  esc_cnt;
  logic [1:0]       seg_len;
  bit               all_dots, fresh, in_seg, over;

  function automatic void canon_new_path();
    wr_pos    = '0;
    in_count  = '0;
    seg_cnt   = '0;
    esc_cnt   = '0;
    seg_len   = '0;
    seg_begin = '0;
    all_dots  = 1'b1;
    fresh     = 1'b1;
    in_seg    = 1'b0;
    over      = 1'b0;
  endfunction

  function automatic void canon_put(logic [UnitW-1:0] u);
    if (wr_pos < MaxUnits) begin
      canon_mem[wr_pos] = u;
      wr_pos++;
    end
  endfunction

  function automatic void canon_close_segment();
    if (in_seg && seg_len != 2'd0) begin
      if (all_dots && seg_len == 2'd1) begin
        wr_pos = seg_begin;
      end else if (all_dots && seg_len == 2'd2) begin
        wr_pos = seg_begin;
        if (seg_cnt == '0) begin
          if (esc_cnt != 8'hFF) esc_cnt++;
        end else begin
          seg_cnt--;
          if (seg_cnt < MaxSegs) wr_pos = seg_start[seg_cnt];
        end
      end else if (seg_cnt < MaxSegs) begin
        seg_start[seg_cnt] = seg_begin;
        seg_cnt++;
      end else begin
        wr_pos = seg_begin;
        over   = 1'b1;
      end
    end
    seg_len  = '0;
    all_dots = 1'b1;
    in_seg   = 1'b0;
  endfunction

  function automatic void canon_append(logic [UnitW-1:0] u);
    bit sep;
    sep = (u == UnitSlash) || (u == UnitBackslash);
    if (in_count >= MaxUnits) begin
      over = 1'b1;
      return;
    end
    in_count++;
    if (fresh) begin
      fresh = 1'b0;
      if (sep) canon_put(UnitBackslash);
    end
    if (sep) begin
      canon_close_segment();
      return;
    end
    if (!in_seg) begin
      in_seg    = 1'b1;
      seg_begin = wr_pos;
      if (seg_cnt != '0) canon_put(UnitBackslash);
    end
    canon_put(u);
    if (seg_len != 2'd3) seg_len++;
    if (u != UnitDot) all_dots = 1'b0;
  endfunction

  function automatic void canon_predict(path_req_t r);
    res_t want;
    want = '0;
    case (r.kind)
      REQ_APPEND: begin
        canon_append(r.unit);
        n_append++;
      end
      REQ_FINISH: begin
        canon_close_segment();
        want.length   = wr_pos;
        want.escapes  = esc_cnt;
        want.overflow = over;
        done_len      = wr_pos;
        n_finish++;
        n_escapes += esc_cnt;
        if (over) n_over_paths++;
        canon_result_q.push_back(want);
        results_due++;
        canon_new_path();
      end
      REQ_READ: begin
        if (r.index < done_len) want.unit = canon_mem[r.index];
        n_read++;
        canon_result_q.push_back(want);
        results_due++;
      end
      default: ;
    endcase
  endfunction

  // stimulus builders
  task automatic push_req(req_e k, logic [UnitW-1:0] u, logic [IdxW-1:0] idx);
    path_req_t r;
    r.kind    = k;
    r.unit    = u;
    r.index   = idx;
    r.drain   = hold_next;
    hold_next = 1'b0;
    req_q.push_back(r);
    if (k != REQ_NONE) n_items++;
  endtask

  task automatic push_unit(logic [UnitW-1:0] u);
    push_req(REQ_APPEND, u, $urandom);
  endtask

  task automatic push_read(logic [IdxW-1:0] idx);
    push_req(REQ_READ, $urandom, idx);
  endtask

  function automatic logic [UnitW-1:0] name_unit();
    case ($urandom_range(0, 11))
      7, 8:    return UnitDot;
      9:       return $urandom;
      10:      return {8'($urandom_range(1, 255)), UnitSlash[7:0]};
      11:      return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'h0061 + 16'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic push_separator();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    repeat (n) push_unit($urandom_range(0, 1) ? UnitSlash : UnitBackslash);
  endtask

  task automatic push_segment();
    int n;
    case ($urandom_range(0, 9))
      0:       push_unit(UnitDot);
      1, 2:    repeat (2) push_unit(UnitDot);
      3:       repeat (3) push_unit(UnitDot);
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) push_unit(name_unit());
      end
    endcase
  endtask

  task automatic push_finish_and_reads(int max_idx);
    push_req(REQ_FINISH, $urandom, $urandom);
    repeat ($urandom_range(0, 6))
      push_read($urandom_range(0, 1) ? $urandom_range(0, max_idx) : $urandom);
  endtask

  task automatic push_path(int segs);
    int k;
    if ($urandom_range(0, 1)) push_separator();
    for (k = 0; k < segs; k++) begin
      if (k != 0) push_separator();
      push_segment();
      if ($urandom_range(0, 19) == 0) push_read($urandom_range(0, 40));
    end
    if ($urandom_range(0, 3) == 0) push_separator();
    push_finish_and_reads(24);
  endtask

  // climbs above the base with a run of parent segments
  task automatic push_climb();
    int k;
    int n;
    n = $urandom_range(1, 40);
    for (k = 0; k < n; k++) begin
      repeat (2) push_unit(UnitDot);
      push_separator();
      if ($urandom_range(0, 3) == 0) begin
        push_segment();
        push_separator();
      end
    end
    push_segment();
    push_finish_and_reads(24);
  endtask

  // more units than the buffer holds
  task automatic push_overflow_path();
    repeat ($urandom_range(257, 300)) begin
      if ($urandom_range(0, 4) == 0) push_separator();
      else push_unit(name_unit());
    end
    push_finish_and_reads(255);
  endtask

  // one-unit segments up to the full segment stack
  task automatic push_deep_path();
    int k;
    for (k = 0; k < MaxSegs; k++) begin
      push_unit(16'h0061 + 16'($urandom_range(0, 25)));
      if (k != MaxSegs - 1) push_unit($urandom_range(0, 1) ? UnitSlash : UnitBackslash);
    end
    push_finish_and_reads(255);
  endtask

  task automatic push_noise();
    repeat ($urandom_range(3, 20)) push_req(req_e'($urandom_range(0, 3)), $urandom, $urandom);
  endtask

  // driver and predictor
  path_req_t cur_req;
  int        burst_left = 1;
  int        gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) canon_predict(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (req_q.size() == 0 ||
                     (req_q[0].drain && results_due != results_seen)) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.index, cur_req.unit};
          s_axis_tuser  <= cur_req.kind;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver stall pattern
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  logic [1:0] rx_phase = '0;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= rx_mode_e'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    rx_phase <= rx_phase + 2'd1;
    case (rx_mode)
      RX_OPEN:         m_axis_tready <= 1'b1;
      RX_RANDOM:       m_axis_tready <= ($urandom_range(0, 9) < 7);
      RX_EVERY_FOURTH: m_axis_tready <= (rx_phase == 2'd0);
      default:         m_axis_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // monitor
  task automatic report_field(string name, int want, int got);
    n_errors++;
    $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.unit     = m_axis_tdata[15:0];
      got.length   = m_axis_tdata[24:16];
      got.escapes  = m_axis_tdata[32:25];
      got.overflow = m_axis_tdata[33];
      results_seen <= results_seen + 1;
      if (canon_result_q.size() == 0) begin
        report_field("unexpected item, tdata", 0, m_axis_tdata);
      end else begin
        want = canon_result_q.pop_front();
        if (got.unit !== want.unit) report_field("unit_out", want.unit, got.unit);
        if (got.length !== want.length)
          report_field("path_length", want.length, got.length);
        if (got.escapes !== want.escapes)
          report_field("escape_count", want.escapes, got.escapes);
        if (got.overflow !== want.overflow)
          report_field("overflow", want.overflow, got.overflow);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [UnitW-1:0] dir_units [19];
    int session;
    int pick;
    int w;
    bit leftover;
    dir_units = '{UnitSlash, UnitSlash, 16'h0061, UnitBackslash, UnitDot, UnitSlash,
                  16'h0062, 16'h0000, UnitSlash, UnitDot, UnitDot, UnitSlash,
                  UnitDot, UnitDot, UnitSlash, UnitDot, UnitDot, UnitBackslash,
                  16'hFFFF};
    canon_new_path();

    // empty path, read past length, unused request code
    push_req(REQ_FINISH, $urandom, $urandom);
    push_read(8'd0);
    push_req(REQ_NONE, $urandom, $urandom);
    // leading and doubled separators, dropped dot, parent pops and one escape
    foreach (dir_units[i]) push_unit(dir_units[i]);
    push_req(REQ_FINISH, $urandom, $urandom);
    push_read(8'd0);
    push_read(8'd1);
    push_read(8'd2);
    push_read(8'd255);

    hold_next = 1'b1;
    session = 0;
    while (n_items < 1300) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) hold_next = 1'b1;
      if (session == 30) push_overflow_path();
      else if (session == 50) push_deep_path();
      else if (pick < 75) push_path($urandom_range(0, 8));
      else if (pick < 86) push_noise();
      else if (pick < 98) push_climb();
      else if (pick < 99) push_overflow_path();
      else push_deep_path();
      session++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    for (w = 0; w < 20000 && canon_result_q.size() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    leftover = (canon_result_q.size() != 0);
    if (leftover) $display("%0t: %0d expected items never came", $time, canon_result_q.size());

    $display("ran %0d appends, %0d finishes and %0d reads over %0d path sessions",
             n_append, n_finish, n_read, session);
    $display("%0d finished paths overflowed, %0d escapes counted", n_over_paths, n_escapes);
    if (n_errors == 0 && !leftover) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
